// ----- sv/dlp_pkg.sv -----
`default_nettype none
package dlp_pkg;

   localparam int LINE_CHARS_DEF = 16;

   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int VALUE_W  = 32;
   localparam int DCOUNT_W = 4;
   localparam int KIND_W   = 2;
   localparam int RSP_PAD_W  = 4;
   localparam int RSP_DATA_W = BYTE_W + VALUE_W + DCOUNT_W + RSP_PAD_W;

   localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'd127;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

   typedef struct packed {
      logic clear;
      logic step;
   } acc_ctl_type;

endpackage
`default_nettype wire

// ----- sv/dlp_ram.sv -----
`default_nettype none
module dlp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 15,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/dlp_acc.sv -----
`default_nettype none
module dlp_acc (
   input  wire logic                  clock,
   input  wire dlp_pkg::acc_ctl_type  ctl,
   input  wire logic [3:0]            digit,
   output logic      [31:0]           acc
);
   import dlp_pkg::*;

   logic [VALUE_W-1:0] acc_ff;
   logic [VALUE_W-1:0] acc_in;

   // times ten as two shifts and an add, wraps modulo 2^32
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.step) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + VALUE_W'(digit);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ----- sv/dlp_ctrl.sv -----
`default_nettype none
module dlp_ctrl #(
   parameter int LINE_CHARS = dlp_pkg::LINE_CHARS_DEF,
   parameter int DEPTH      = LINE_CHARS - 1,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [1:0]           rsp_kind,
   output logic      [7:0]           rsp_char,
   output logic      [31:0]          rsp_value,
   output logic      [3:0]           rsp_digits,
   output logic                      rsp_last,
   output logic                      ram_wr_en,
   output logic      [AW-1:0]        ram_wr_addr,
   output logic      [3:0]           ram_wr_data,
   output logic                      ram_rd_en,
   output logic      [AW-1:0]        ram_rd_addr,
   output dlp_pkg::acc_ctl_type      acc_ctl,
   input  wire logic [31:0]          acc_value
);
   import dlp_pkg::*;

   localparam int CW = $clog2(LINE_CHARS);

   typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_BACK, ST_CONV} state_type;

   state_type           state_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       rd_ptr_ff;
   logic                rd_vld_ff;
   logic [1:0]          bs_idx_ff;
   logic [KIND_W-1:0]   pend_kind_ff;
   logic [BYTE_W-1:0]   pend_char_ff;
   logic [VALUE_W-1:0]  pend_value_ff;
   logic [DCOUNT_W-1:0] pend_digits_ff;
   logic                out_valid_ff;
   logic [KIND_W-1:0]   out_kind_ff;
   logic [BYTE_W-1:0]   out_char_ff;
   logic [VALUE_W-1:0]  out_value_ff;
   logic [DCOUNT_W-1:0] out_digits_ff;
   logic                out_last_ff;

   logic accept;
   logic is_digit;
   logic is_back;
   logic is_enter;
   logic has_room;
   logic slot_free;
   logic rd_more;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_digit   = req_tdata inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_back    = req_tdata inside {CHAR_BS, CHAR_DEL};
   assign is_enter   = req_tdata inside {CHAR_CR, CHAR_LF};
   assign has_room   = count_ff < CW'(DEPTH);
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign rd_more    = rd_ptr_ff < count_ff;

   assign ram_wr_en   = accept && is_digit && has_room;
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = DIGIT_W'(req_tdata - CHAR_ZERO);
   assign ram_rd_en   = (state_ff == ST_CONV) && rd_more;
   assign ram_rd_addr = rd_ptr_ff[AW-1:0];

   assign acc_ctl.clear = accept;
   assign acc_ctl.step  = (state_ff == ST_CONV) && rd_vld_ff;

   always_ff @(posedge clock) begin
      if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_enter) begin
                  if (count_ff != '0) begin
                     rd_ptr_ff <= '0;
                     rd_vld_ff <= 1'b0;
                     state_ff  <= ST_CONV;
                  end else begin
                     pend_kind_ff   <= KIND_REJECT;
                     pend_char_ff   <= '0;
                     pend_value_ff  <= '0;
                     pend_digits_ff <= '0;
                     state_ff       <= ST_EMIT;
                  end
               end else if (is_back) begin
                  if (count_ff != '0) begin
                     count_ff  <= count_ff - 1'b1;
                     bs_idx_ff <= '0;
                     state_ff  <= ST_BACK;
                  end
               end else if (is_digit && has_room) begin
                  count_ff       <= count_ff + 1'b1;
                  pend_kind_ff   <= KIND_ECHO;
                  pend_char_ff   <= req_tdata;
                  pend_value_ff  <= '0;
                  pend_digits_ff <= '0;
                  state_ff       <= ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_ff  <= 1'b1;
               out_kind_ff   <= pend_kind_ff;
               out_char_ff   <= pend_char_ff;
               out_value_ff  <= pend_value_ff;
               out_digits_ff <= pend_digits_ff;
               out_last_ff   <= 1'b1;
               state_ff      <= ST_IDLE;
            end
         end
         ST_BACK: begin
            if (slot_free) begin
               out_valid_ff  <= 1'b1;
               out_kind_ff   <= KIND_ECHO;
               out_char_ff   <= (bs_idx_ff == 2'd1) ? CHAR_SPACE : CHAR_BS;
               out_value_ff  <= '0;
               out_digits_ff <= '0;
               out_last_ff   <= (bs_idx_ff == 2'd2);
               bs_idx_ff     <= bs_idx_ff + 2'd1;
               if (bs_idx_ff == 2'd2) begin
                  state_ff <= ST_IDLE;
               end
            end
         end
         ST_CONV: begin
            // the read of entry k issues in the cycle before its accumulate
            if (rd_more) begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
               rd_vld_ff <= 1'b1;
            end else begin
               rd_vld_ff <= 1'b0;
               if (!rd_vld_ff) begin
                  pend_kind_ff   <= KIND_NUMBER;
                  pend_char_ff   <= '0;
                  pend_value_ff  <= acc_value;
                  pend_digits_ff <= DCOUNT_W'(count_ff);
                  count_ff       <= '0;
                  state_ff       <= ST_EMIT;
               end
            end
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_digits = out_digits_ff;
   assign rsp_last   = out_last_ff;

endmodule
`default_nettype wire

// ----- sv/decimal_line_entry_parser.sv -----
`default_nettype none
// channel   direction  tdata                                          tuser          tlast
// req       in         rx_byte[7:0]                                   -              -
// rsp       out        echo_char, number_value, digits_entered, pad   out_kind[1:0]  last_of_run
//
// a digit or an empty enter goes from the request through the emit state to the result register;
// a backspace echoes backspace, space, backspace from the back state, one echoed byte at a time;
// enter with n stored digits reads the store one digit per cycle, then emits the number.
// the next request is taken as soon as the last result sits in the output register.
// synchronous reset empties the count; the digit store is not cleared.
// a stalled rsp_tready holds the result register and the emit and backspace states behind it.
module decimal_line_entry_parser #(
   parameter int LINE_CHARS = dlp_pkg::LINE_CHARS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // rx_byte[7:0]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // echo_char[7:0], number_value[39:8], digits_entered[43:40], zero[47:44]
   output logic      [dlp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic      [1:0]                      rsp_tuser,  // out_kind[1:0]
   output logic                                 rsp_tlast
);
   import dlp_pkg::*;

   localparam int DEPTH = LINE_CHARS - 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [DIGIT_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [DIGIT_W-1:0]  ram_rd_data;
   acc_ctl_type         acc_ctl;
   logic [VALUE_W-1:0]  acc_value;
   logic [BYTE_W-1:0]   rsp_char;
   logic [VALUE_W-1:0]  rsp_value;
   logic [DCOUNT_W-1:0] rsp_digits;

   dlp_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dlp_acc u_acc (
      .clock (clock),
      .ctl   (acc_ctl),
      .digit (ram_rd_data),
      .acc   (acc_value)
   );

   dlp_ctrl #(
      .LINE_CHARS (LINE_CHARS),
      .DEPTH      (DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_char    (rsp_char),
      .rsp_value   (rsp_value),
      .rsp_digits  (rsp_digits),
      .rsp_last    (rsp_tlast),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .acc_ctl     (acc_ctl),
      .acc_value   (acc_value)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_digits, rsp_value, rsp_char};

endmodule
`default_nettype wire

// ----- sim/decimal_line_entry_parser_tb.sv -----
`timescale 1ns / 1ps
module decimal_line_entry_parser_tb;
   import dlp_pkg::*;

   localparam int STORE_DEPTH = LINE_CHARS_DEF - 1;
   localparam int RANDOM_BYTES = 470;
   localparam int CALM_FROM = 1500;
   localparam int CALM_TO = 2600;
   localparam int HOLD_AT = 500;
   localparam int HOLD_LEN = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   echo;
      logic [VALUE_W-1:0]  value;
      logic [DCOUNT_W-1:0] ndigits;
      logic                last;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   logic [7:0] rx_bytes[$];
   line_result_type due_results[$];
   logic [DIGIT_W-1:0] typed_digits[STORE_DEPTH];
   int digit_total = 0;
   int n_accepted = 0;
   int n_errors = 0;
   int unsigned cycle_n = 0;
   int hold_left = 0;
   int stall_n = 0;

   decimal_line_entry_parser dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic bit take_gap();
      if (cycle_n >= CALM_FROM && cycle_n < CALM_TO) return 1'b0;
      return $urandom_range(99) < 27;
   endfunction

   task automatic owe_result(input logic [KIND_W-1:0] kind, input logic [7:0] echo,
                             input logic [31:0] value, input logic [3:0] ndigits,
                             input logic last);
      line_result_type r;
      r.kind = kind;
      r.echo = echo;
      r.value = value;
      r.ndigits = ndigits;
      r.last = last;
      due_results.push_back(r);
   endtask

   // line editor: digits collect, backspace drops one, enter converts
   task automatic parse_rx_byte(input logic [7:0] b);
      logic [31:0] acc;
      if (b == CHAR_CR || b == CHAR_LF) begin
         if (digit_total > 0) begin
            acc = '0;
            for (int i = 0; i < digit_total; i++) acc = acc * 32'd10 + 32'(typed_digits[i]);
            owe_result(KIND_NUMBER, 8'd0, acc, digit_total[3:0], 1'b1);
            digit_total = 0;
         end else begin
            owe_result(KIND_REJECT, 8'd0, 32'd0, 4'd0, 1'b1);
         end
      end else if (b == CHAR_BS || b == CHAR_DEL) begin
         if (digit_total > 0) begin
            digit_total--;
            owe_result(KIND_ECHO, CHAR_BS, 32'd0, 4'd0, 1'b0);
            owe_result(KIND_ECHO, CHAR_SPACE, 32'd0, 4'd0, 1'b0);
            owe_result(KIND_ECHO, CHAR_BS, 32'd0, 4'd0, 1'b1);
         end
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         // a full store drops the digit silently
         if (digit_total < STORE_DEPTH) begin
            typed_digits[digit_total] = 4'(b - CHAR_ZERO);
            digit_total++;
            owe_result(KIND_ECHO, b, 32'd0, 4'd0, 1'b1);
         end
      end
   endtask

   task automatic flag_error(input string what);
      n_errors++;
      if (n_errors <= 10) $display("mismatch at cycle %0d: %s", cycle_n, what);
   endtask

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (rx_bytes.size() != 0 && !take_gap()) begin
               req_tvalid <= 1'b1;
               req_tdata <= rx_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (cycle_n == HOLD_AT) hold_left <= HOLD_LEN;
         else if (hold_left != 0) hold_left <= hold_left - 1;
         rsp_tready <= (hold_left == 0) && (cycle_n != HOLD_AT) && !take_gap();
      end
   end

   // response monitor
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            flag_error($sformatf("unexpected response tuser=%0d tdata=%h tlast=%b",
                                 rsp_tuser, rsp_tdata, rsp_tlast));
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.kind)
               flag_error($sformatf("out_kind exp %0d got %0d", want.kind, rsp_tuser));
            if (rsp_tdata[7:0] !== want.echo)
               flag_error($sformatf("echo_char exp %h got %h", want.echo, rsp_tdata[7:0]));
            if (rsp_tdata[39:8] !== want.value)
               flag_error($sformatf("number_value exp %0d got %0d", want.value,
                                    rsp_tdata[39:8]));
            if (rsp_tdata[43:40] !== want.ndigits)
               flag_error($sformatf("digits_entered exp %0d got %0d", want.ndigits,
                                    rsp_tdata[43:40]));
            if (rsp_tdata[47:44] !== 4'd0)
               flag_error($sformatf("pad bits exp 0 got %h", rsp_tdata[47:44]));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last_of_run exp %b got %b", want.last, rsp_tlast));
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_n <= 0;
      end else if (stall_n >= STALL_LIMIT) begin
         $display("decimal_line_entry_parser_tb: FAIL");
         $finish;
      end else begin
         stall_n <= stall_n + 1;
      end
   end

   initial begin
      int total;
      int n;
      int base;

      // empty-line cases
      rx_bytes.push_back(CHAR_CR);
      rx_bytes.push_back(CHAR_BS);
      // fill the store; fifteen digits wrap the value
      rx_bytes.push_back(CHAR_ZERO);
      repeat (STORE_DEPTH - 1) rx_bytes.push_back(CHAR_NINE);
      rx_bytes.push_back(8'd52);
      rx_bytes.push_back(CHAR_DEL);
      rx_bytes.push_back(8'd55);
      rx_bytes.push_back(CHAR_CR);
      // bytes that are ignored, then a one-digit line and an empty line
      rx_bytes.push_back(8'd0);
      rx_bytes.push_back(8'd255);
      rx_bytes.push_back(8'd58);
      rx_bytes.push_back(8'd47);
      rx_bytes.push_back(CHAR_DEL);
      rx_bytes.push_back(CHAR_NINE);
      rx_bytes.push_back(CHAR_LF);
      rx_bytes.push_back(CHAR_LF);

      base = rx_bytes.size();
      while (rx_bytes.size() < base + RANDOM_BYTES) begin
         if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom_range(255)));
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(STORE_DEPTH + 4) : $urandom_range(8);
            for (int k = 0; k < n; k++) begin
               rx_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
               if ($urandom_range(99) < 12)
                  rx_bytes.push_back($urandom_range(1) ? CHAR_BS : CHAR_DEL);
               if ($urandom_range(99) < 6) rx_bytes.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 8) rx_bytes.push_back($urandom_range(1) ? CHAR_BS : CHAR_DEL);
            rx_bytes.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end
      end
      total = rx_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < total) @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (n_errors == 0) begin
         $display("decimal_line_entry_parser_tb: PASS");
      end else begin
         $display("decimal_line_entry_parser_tb: FAIL");
      end
      $finish;
   end

endmodule
